### hdl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hdl/irdal_pkg.sv
// constants and types for the ir distance averaging linearizer
package irdal_pkg;

  localparam int RAW_W     = 10;
  localparam int DIST_W    = 17;
  localparam int CFG_IDX_W = 2;
  localparam int TAPS_DEF  = 10;

  localparam logic [RAW_W-1:0]  RAW_MIN_RST = 10'd80;
  localparam logic [RAW_W-1:0]  RAW_MAX_RST = 10'd500;
  localparam logic [RAW_W-1:0]  BIAS        = 10'd3;
  localparam logic [DIST_W-1:0] DIST_MAX    = 17'd131071;
  localparam logic [DIST_W-1:0] NUM_Q4      = 17'd108592;  // 6787 * 16
  localparam logic [DIST_W-1:0] OFFSET_Q4   = 17'd64;      // 4 * 16

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAW_MIN = 2'd0,
    REG_RAW_MAX = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MEAN,
    ST_LIN,
    ST_DONE
  } state_t;

endpackage

### hdl/ir_distance_average_linearizer_top.sv
// ir range sensor clamp, moving average and reciprocal linearization
//
//  channel | signals                        | direction | handshake
//  --------+--------------------------------+-----------+----------------
//  in      | sample                         | input     | in_valid/in_stall
//  out     | raw_average, distance_q4       | output    | out_valid/out_stall
//  cfg     | cfg_index, cfg_data            | input     | cfg_valid/cfg_ready
//
// each word runs through these steps before the next is accepted: acceptance in
// idle, the mean state that forms the window mean by a constant reciprocal
// multiply, a restoring divider making one quotient bit a cycle for the
// reciprocal, and the done state that loads the output register once it is
// free (done waits while out_stall holds the last result). a mean of three
// or less skips the divider. reset clears the sample window and running sum
// and reloads the default limits; no clearing pass. in_stall is high while a
// word is in flight; a finished result waits in the output register, so the
// next word can enter while out_stall holds it.
`include "assert_macros.svh"

module ir_distance_average_linearizer_top #(
  parameter int TAPS = irdal_pkg::TAPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [irdal_pkg::RAW_W-1:0]   sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [irdal_pkg::RAW_W-1:0]   raw_average,
  output logic [irdal_pkg::DIST_W-1:0]  distance_q4,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [irdal_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [irdal_pkg::RAW_W-1:0]   cfg_data
);

  localparam int RAW_W   = irdal_pkg::RAW_W;
  localparam int DIST_W  = irdal_pkg::DIST_W;
  localparam int SUM_W   = RAW_W + $clog2(TAPS);
  localparam int DIV_W   = DIST_W;
  localparam int CNT_W   = $clog2(DIV_W);
  // floor(sum / TAPS) as (sum * MEAN_MUL) >> MEAN_SH, exact for any sum below 2**SUM_W
  localparam int MEAN_SH = SUM_W + $clog2(TAPS);
  localparam int MUL_W   = SUM_W + 2;
  localparam int PROD_W  = SUM_W + MUL_W;
  localparam logic [MUL_W-1:0] MEAN_MUL =
    MUL_W'(((64'd1 << MEAN_SH) + 64'(TAPS) - 64'd1) / 64'(TAPS));

  irdal_pkg::state_t state, state_next;

  logic [RAW_W-1:0] raw_min, raw_max;
  logic [RAW_W-1:0] hist [TAPS];
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_next;
  logic [RAW_W-1:0] clamped;

  logic [PROD_W-1:0] mean_prod;
  logic [RAW_W-1:0]  mean_calc;

  logic [DIV_W-1:0] div_num;
  logic [RAW_W-1:0] div_rem;
  logic [RAW_W-1:0] div_den;
  logic [CNT_W-1:0] cnt;
  logic [RAW_W-1:0] mean;
  logic [DIST_W-1:0] dist_q4;

  logic [RAW_W:0]   rem_sh;
  logic             q_bit;
  logic [RAW_W-1:0] rem_new;
  logic [DIV_W-1:0] num_new;
  logic             last_step;
  logic [DIST_W-1:0] quot_new;

  logic accept;
  logic load_out;

  assign cfg_ready = 1'b1;

  // clamp: upper limit is checked first, so it wins for samples above it when the limits cross
  always_comb begin
    if (sample > raw_max) begin
      clamped = raw_max;
    end else if (sample < raw_min) begin
      clamped = raw_min;
    end else begin
      clamped = sample;
    end
  end

  assign sum_next = sum - SUM_W'(hist[TAPS-1]) + SUM_W'(clamped);

  // window mean from the registered running sum
  assign mean_prod = PROD_W'(sum) * PROD_W'(MEAN_MUL);
  assign mean_calc = mean_prod[MEAN_SH +: RAW_W];

  // restoring divider step
  assign rem_sh    = {div_rem, div_num[DIV_W-1]};
  assign q_bit     = (rem_sh >= {1'b0, div_den});
  assign rem_new   = q_bit ? RAW_W'(rem_sh - {1'b0, div_den}) : rem_sh[RAW_W-1:0];
  assign num_new   = {div_num[DIV_W-2:0], q_bit};
  assign last_step = (cnt == CNT_W'(DIV_W - 1));
  assign quot_new  = num_new[DIST_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      irdal_pkg::ST_IDLE: begin
        if (in_valid) state_next = irdal_pkg::ST_MEAN;
      end
      irdal_pkg::ST_MEAN: begin
        state_next = (mean_calc <= irdal_pkg::BIAS) ? irdal_pkg::ST_DONE
                                                    : irdal_pkg::ST_LIN;
      end
      irdal_pkg::ST_LIN: begin
        if (last_step) state_next = irdal_pkg::ST_DONE;
      end
      irdal_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) state_next = irdal_pkg::ST_IDLE;
      end
      default: state_next = irdal_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    load_out = 1'b0;
    unique case (state)
      irdal_pkg::ST_IDLE: in_stall = 1'b0;
      irdal_pkg::ST_DONE: load_out = !out_valid || !out_stall;
      default: ;
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= irdal_pkg::ST_IDLE;
      raw_min <= irdal_pkg::RAW_MIN_RST;
      raw_max <= irdal_pkg::RAW_MAX_RST;
      sum     <= '0;
      for (int i = 0; i < TAPS; i++) hist[i] <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == irdal_pkg::REG_RAW_MIN) begin
          raw_min <= cfg_data;
        end else if (cfg_index == irdal_pkg::REG_RAW_MAX) begin
          raw_max <= cfg_data;
        end
      end

      if (accept) begin
        hist[0] <= clamped;
        for (int i = 1; i < TAPS; i++) hist[i] <= hist[i-1];
        sum <= sum_next;
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // divider and result datapath
  always_ff @(posedge clk) begin
    if (state == irdal_pkg::ST_MEAN) begin
      mean    <= mean_calc;
      // reciprocal of the biased mean, unused when the mean saturates
      div_num <= DIV_W'(irdal_pkg::NUM_Q4);
      div_den <= mean_calc - irdal_pkg::BIAS;
      div_rem <= '0;
      cnt     <= '0;
      if (mean_calc <= irdal_pkg::BIAS) begin
        dist_q4 <= irdal_pkg::DIST_MAX;
      end
    end else if (state == irdal_pkg::ST_LIN) begin
      div_num <= num_new;
      div_rem <= rem_new;
      cnt     <= cnt + CNT_W'(1);
      if (last_step) begin
        dist_q4 <= (quot_new < irdal_pkg::OFFSET_Q4) ? '0
                                                     : quot_new - irdal_pkg::OFFSET_Q4;
      end
    end
    if (load_out) begin
      raw_average <= mean;
      distance_q4 <= dist_q4;
    end
  end

  `ASSERT_IMPLIES(a_rem_below_den, clk, rst, (state == irdal_pkg::ST_LIN), (div_rem < div_den))
  `ASSERT_NEXT(a_accept_starts_mean, clk, rst, accept, (state == irdal_pkg::ST_MEAN))
  `ASSERT_IMPLIES(a_low_mean_saturates, clk, rst,
                  (out_valid && raw_average <= irdal_pkg::BIAS),
                  (distance_q4 == irdal_pkg::DIST_MAX))
  `ASSERT_NEXT(a_load_shows_valid, clk, rst, load_out, out_valid)

endmodule

### bench/ir_distance_average_linearizer_top_test.sv
// testbench for the ir distance averaging linearizer: directed and random words, scored live
module ir_distance_average_linearizer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAW_W = irdal_pkg::RAW_W;
  localparam int DIST_W = irdal_pkg::DIST_W;
  localparam int CFG_IDX_W = irdal_pkg::CFG_IDX_W;
  localparam int TAPS = irdal_pkg::TAPS_DEF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 100;

  // index values past the last register, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct {
    logic [RAW_W-1:0]  raw_average;
    logic [DIST_W-1:0] distance_q4;
  } reading_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [RAW_W-1:0]     sample = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [RAW_W-1:0]     raw_average;
  logic [DIST_W-1:0]    distance_q4;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RAW_W-1:0]     cfg_data = '0;

  // predictor state
  logic [RAW_W-1:0] lim_min = irdal_pkg::RAW_MIN_RST;
  logic [RAW_W-1:0] lim_max = irdal_pkg::RAW_MAX_RST;
  logic [RAW_W-1:0] window [TAPS];
  reading_t         pending_readings [$];

  int          errors = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  ir_distance_average_linearizer_top #(.TAPS(TAPS)) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .raw_average (raw_average),
    .distance_q4 (distance_q4),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic reading_t average_and_linearize(input logic [RAW_W-1:0] s);
    logic [RAW_W-1:0] c;
    int unsigned sum;
    int unsigned mean;
    int unsigned q;
    reading_t r;
    // upper limit is checked first, so it wins for samples above it when the limits are crossed
    if (s > lim_max) c = lim_max;
    else if (s < lim_min) c = lim_min;
    else c = s;
    for (int i = TAPS - 1; i > 0; i--) window[i] = window[i - 1];
    window[0] = c;
    sum = 0;
    for (int i = 0; i < TAPS; i++) sum += 32'(window[i]);
    mean = sum / TAPS;
    r.raw_average = mean[RAW_W-1:0];
    if (mean <= irdal_pkg::BIAS) begin
      r.distance_q4 = irdal_pkg::DIST_MAX;
    end else begin
      q = irdal_pkg::NUM_Q4 / (mean - irdal_pkg::BIAS);
      if (q < irdal_pkg::OFFSET_Q4) q = 0;
      else q = q - irdal_pkg::OFFSET_Q4;
      if (q > irdal_pkg::DIST_MAX) q = irdal_pkg::DIST_MAX;
      r.distance_q4 = q[DIST_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [RAW_W-1:0] pick_sample();
    int unsigned r;
    int unsigned lim;
    r = $urandom_range(0, 9);
    if (r < 6) return RAW_W'($urandom_range(0, 1023));
    if (r < 8) begin
      lim = (r == 6) ? 32'(lim_min) : 32'(lim_max);
      return RAW_W'($urandom_range((lim < 2) ? 0 : lim - 2, (lim > 1021) ? 1023 : lim + 2));
    end
    return RAW_W'($urandom_range(0, 15));
  endfunction

  task automatic send_sample(input logic [RAW_W-1:0] s);
    if (idle_pct != 0) begin
      while ($urandom_range(1, 100) <= idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_readings.push_back(average_and_linearize(s));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  // writes both limits, then a spare index that must change nothing
  task automatic set_limits(input logic [RAW_W-1:0] lo, input logic [RAW_W-1:0] hi);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [RAW_W-1:0]     val [3];
    idx[0] = irdal_pkg::REG_RAW_MIN;
    val[0] = lo;
    idx[1] = irdal_pkg::REG_RAW_MAX;
    val[1] = hi;
    idx[2] = $urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3;
    val[2] = RAW_W'($urandom);
    wait_drained();
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx[k])
        irdal_pkg::REG_RAW_MIN: lim_min = val[k];
        irdal_pkg::REG_RAW_MAX: lim_max = val[k];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [RAW_W-1:0] lo, input logic [RAW_W-1:0] hi,
                           input int unsigned idle, input int unsigned stall, input int count);
    set_limits(lo, hi);
    idle_pct = idle;
    stall_pct = stall;
    for (int n = 0; n < count; n++) send_sample(pick_sample());
  endtask

  task automatic test_reset_limits();
    send_sample(10'd1023);
    send_sample(10'd0);
    send_sample(10'd500);
    send_sample(10'd80);
    send_sample(10'd501);
    send_sample(10'd79);
  endtask

  // flush the window with zeros, then walk the mean through 3 and 4
  task automatic test_low_mean_saturation();
    set_limits(10'd0, 10'd1023);
    for (int n = 0; n < TAPS; n++) send_sample(10'd0);
    send_sample(10'd30);
    send_sample(10'd10);
    send_sample(10'd1023);
  endtask

  task automatic test_crossed_limits();
    set_limits(10'd600, 10'd200);
    send_sample(10'd100);
    send_sample(10'd300);
    send_sample(10'd700);
    send_sample(10'd400);
  endtask

  task automatic test_random_traffic();
    int unsigned lo;
    int unsigned hi;
    run_phase(10'd0, 10'd1023, 0, 0, 80);
    run_phase(10'd0, 10'd1023, 51, 0, 60);
    lo = $urandom_range(0, 511);
    hi = $urandom_range(lo, 1023);
    run_phase(RAW_W'(lo), RAW_W'(hi), 0, 51, 60);
    run_phase(10'd0, 10'd15, 14, 14, 60);
    run_phase(10'd1023, 10'd1023, 51, 0, 40);
    lo = $urandom_range(512, 1023);
    hi = $urandom_range(0, lo - 1);
    run_phase(RAW_W'(lo), RAW_W'(hi), 0, 51, 50);
    lo = $urandom_range(0, 1023);
    hi = $urandom_range(0, 1023);
    run_phase(RAW_W'(lo), RAW_W'(hi), 14, 14, 80);
  endtask

  // receiver holds off while words keep coming, so the input side backs up
  task automatic test_output_backpressure();
    set_limits(10'd0, 10'd1023);
    idle_pct = 0;
    stall_pct = 0;
    hold_requests++;
    for (int n = 0; n < 40; n++) send_sample(pick_sample());
  endtask

  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(1, 100) <= stall_pct);
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        $error("unexpected word: raw_average %0d, distance_q4 %0d", raw_average, distance_q4);
        errors++;
      end else begin
        want = pending_readings.pop_front();
        if (raw_average !== want.raw_average) begin
          $error("raw_average: expected %0d, got %0d", want.raw_average, raw_average);
          errors++;
        end
        if (distance_q4 !== want.distance_q4) begin
          $error("distance_q4: expected %0d, got %0d", want.distance_q4, distance_q4);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < TAPS; i++) window[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_limits();
    test_low_mean_saturation();
    test_crossed_limits();
    test_random_traffic();
    test_output_backpressure();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/irdal_pkg.sv
hdl/ir_distance_average_linearizer_top.sv
bench/ir_distance_average_linearizer_top_test.sv
